// ===== sv/gasp_pkg.sv =====
// ----------------------------------------------------------------------------
// gasp_pkg: shared types, codes and tables of the grid path planner
// Holds field widths, command and status codes, register indexes, the
// neighbour step tables and the demo floor map used at reset.
// ----------------------------------------------------------------------------
package gasp_pkg;

    // default map size
    localparam int MAP_ROWS_DEF = 7;
    localparam int MAP_COLS_DEF = 4;

    // field widths of the stream payload
    localparam int ROW_FW    = 3;
    localparam int COL_FW    = 2;
    localparam int CODE_FW   = 5;
    localparam int HEAD_FW   = 3;
    localparam int STATUS_FW = 3;
    localparam int DIR_FW    = 4;
    localparam int LINK_W    = 9;

    // cell codes
    localparam logic signed [CODE_FW-1:0] CODE_WALL = -5'sd1;
    localparam logic signed [CODE_FW-1:0] CODE_ROAD = 5'sd0;

    // commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_PLAN  = 1'b1;

    // result status codes
    localparam logic [STATUS_FW-1:0] STS_WRITE_DONE = 3'd0;
    localparam logic [STATUS_FW-1:0] STS_MARKER     = 3'd1;
    localparam logic [STATUS_FW-1:0] STS_EMPTY      = 3'd2;
    localparam logic [STATUS_FW-1:0] STS_NO_GOAL    = 3'd3;
    localparam logic [STATUS_FW-1:0] STS_UNREACH    = 3'd4;

    // register indexes
    localparam logic [1:0] REG_DIAG_A = 2'd0;
    localparam logic [1:0] REG_DIAG_B = 2'd1;
    localparam logic [1:0] REG_BLK_A  = 2'd2;
    localparam logic [1:0] REG_BLK_B  = 2'd3;

    // neighbour moves along one axis
    localparam logic [1:0] MV_STAY = 2'd0;
    localparam logic [1:0] MV_DEC  = 2'd1;
    localparam logic [1:0] MV_INC  = 2'd2;

    // last orthogonal neighbour index
    localparam logic [2:0] LAST_ORTHO = 3'd3;
    localparam logic [2:0] LAST_DIR   = 3'd7;

    typedef struct packed {
        logic [4:0] diag_a;
        logic [4:0] diag_b;
        logic [4:0] blk_a;
        logic [4:0] blk_b;
    } cfg_t;

    typedef struct packed {
        logic inb;   // neighbour lies on the map
        logic pass;  // neighbour is no wall and the link is allowed
    } nbr_t;

    // row move of neighbour k: up, down, left, right, ur, dr, dl, ul
    function automatic logic [1:0] row_move(input logic [2:0] k);
        logic [1:0] m;
        case (k)
            3'd0, 3'd4, 3'd7: m = MV_DEC;
            3'd1, 3'd5, 3'd6: m = MV_INC;
            default:          m = MV_STAY;
        endcase
        return m;
    endfunction

    function automatic logic [1:0] col_move(input logic [2:0] k);
        logic [1:0] m;
        case (k)
            3'd2, 3'd6, 3'd7: m = MV_DEC;
            3'd3, 3'd4, 3'd5: m = MV_INC;
            default:          m = MV_STAY;
        endcase
        return m;
    endfunction

    // demo floor map; cells outside it are walls
    function automatic logic signed [CODE_FW-1:0] demo_code(input int r, input int c);
        logic signed [CODE_FW-1:0] v;
        v = CODE_WALL;
        case (r)
            0: v = (c == 3) ? 5'sd4 : CODE_WALL;
            1: v = (c == 2 || c == 3) ? CODE_ROAD : CODE_WALL;
            2: v = (c == 1 || c == 3) ? CODE_ROAD : CODE_WALL;
            3: begin
                case (c)
                    0:       v = -5'sd3;
                    3:       v = 5'sd3;
                    default: v = CODE_ROAD;
                endcase
            end
            4, 5: v = (c == 0) ? CODE_ROAD : CODE_WALL;
            6: begin
                case (c)
                    0:       v = 5'sd2;
                    3:       v = 5'sd1;
                    default: v = CODE_ROAD;
                endcase
            end
            default: v = CODE_WALL;
        endcase
        if (c > 3) v = CODE_WALL;
        return v;
    endfunction

endpackage

// ===== sv/gasp_nbr.sv =====
// ----------------------------------------------------------------------------
// gasp_nbr: neighbour evaluation unit
// Steps from the current cell in one of eight directions, checks the map
// bounds, and applies the wall, diagonal and blocked link rules.
// ----------------------------------------------------------------------------
module gasp_nbr #(
    parameter int MAP_ROWS = gasp_pkg::MAP_ROWS_DEF,
    parameter int MAP_COLS = gasp_pkg::MAP_COLS_DEF
) (
    input  logic [$clog2(MAP_ROWS)-1:0]            cur_row,
    input  logic [$clog2(MAP_COLS)-1:0]            cur_col,
    input  logic [2:0]                             dir_idx,
    input  logic signed [gasp_pkg::CODE_FW-1:0]    cur_code,
    input  logic signed [gasp_pkg::CODE_FW-1:0]    nbr_code,
    input  gasp_pkg::cfg_t                         cfg,
    output logic [$clog2(MAP_ROWS)-1:0]            nbr_row,
    output logic [$clog2(MAP_COLS)-1:0]            nbr_col,
    output logic [$clog2(MAP_ROWS*MAP_COLS)-1:0]   nbr_cell,
    output gasp_pkg::nbr_t                         nbr_flags
);
    import gasp_pkg::*;

    localparam int RW    = $clog2(MAP_ROWS);
    localparam int CLW   = $clog2(MAP_COLS);
    localparam int IDX_W = $clog2(MAP_ROWS * MAP_COLS);

    logic [RW-1:0]     step_row;
    logic [CLW-1:0]    step_col;
    logic              row_ok;
    logic              col_ok;
    logic [IDX_W-1:0]  cur_cell;
    logic [LINK_W-1:0] cur_l;
    logic [LINK_W-1:0] nbr_l;
    logic              diag_hit;
    logic              blk_hit;
    logic              link_ok;

    // step along rows
    always_comb
    begin
        step_row = cur_row;
        row_ok   = 1'b1;
        case (row_move(dir_idx))
            MV_DEC:
            begin
                row_ok   = (cur_row != '0);
                step_row = cur_row - RW'(1);
            end
            MV_INC:
            begin
                row_ok   = (cur_row != RW'(MAP_ROWS - 1));
                step_row = cur_row + RW'(1);
            end
            default:
            begin
                step_row = cur_row;
            end
        endcase
    end

    // step along columns
    always_comb
    begin
        step_col = cur_col;
        col_ok   = 1'b1;
        case (col_move(dir_idx))
            MV_DEC:
            begin
                col_ok   = (cur_col != '0);
                step_col = cur_col - CLW'(1);
            end
            MV_INC:
            begin
                col_ok   = (cur_col != CLW'(MAP_COLS - 1));
                step_col = cur_col + CLW'(1);
            end
            default:
            begin
                step_col = cur_col;
            end
        endcase
    end

    // hold the current cell when the step leaves the map
    assign nbr_row  = (row_ok && col_ok) ? step_row : cur_row;
    assign nbr_col  = (row_ok && col_ok) ? step_col : cur_col;
    assign cur_cell = IDX_W'(int'(cur_row) * MAP_COLS + int'(cur_col));
    assign nbr_cell = IDX_W'(int'(nbr_row) * MAP_COLS + int'(nbr_col));

    // match the link against the configured pairs, both directions
    assign cur_l    = LINK_W'(cur_cell);
    assign nbr_l    = LINK_W'(nbr_cell);
    assign diag_hit = (cur_l == LINK_W'(cfg.diag_a) && nbr_l == LINK_W'(cfg.diag_b)) ||
                      (cur_l == LINK_W'(cfg.diag_b) && nbr_l == LINK_W'(cfg.diag_a));
    assign blk_hit  = (cur_l == LINK_W'(cfg.blk_a) && nbr_l == LINK_W'(cfg.blk_b)) ||
                      (cur_l == LINK_W'(cfg.blk_b) && nbr_l == LINK_W'(cfg.blk_a));

    // road to road links obey the diagonal and blocked pairs
    always_comb
    begin
        link_ok = 1'b1;
        if (cur_code == CODE_ROAD && nbr_code == CODE_ROAD)
        begin
            if (dir_idx > LAST_ORTHO)
                link_ok = diag_hit;
            else
                link_ok = !blk_hit;
        end
    end

    assign nbr_flags.inb  = row_ok && col_ok;
    assign nbr_flags.pass = (nbr_code != CODE_WALL) && link_ok;

endmodule

// ===== sv/grid_a_star_path_planner.sv =====
// ----------------------------------------------------------------------------
// grid_a_star_path_planner: A* path search over a small grid map
// Holds the map, takes write and plan commands, and streams path markers.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats on s_* carry one command each. A write command sets one map
//   cell and returns one status beat. A plan command scans the map for the
//   goal marker, runs an 8-neighbour A* search from the start cell and
//   returns the marker cells along the path, tlast on the final beat, or a
//   single status beat (empty path, goal absent, unreachable).
//   The APB port sets the allowed diagonal link and the blocked link; write
//   it only while the block is idle.
//   A plan runs a goal scan, then per expanded node an open list min
//   search, list compaction and neighbour checks through the shared
//   neighbour unit, then the path trace and the emit, which receiver
//   stalls can hold.
//   s_tready is high only while the sequencer is idle.
//   Reset loads the demo floor map and the default link registers.
//   A stalled receiver holds the result register and the sequencer waits.
// ----------------------------------------------------------------------------
module grid_a_star_path_planner #(
    parameter int MAP_ROWS = gasp_pkg::MAP_ROWS_DEF,
    parameter int MAP_COLS = gasp_pkg::MAP_COLS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // stream in
    input  logic        s_tvalid,
    output logic        s_tready,
    // cell_row, cell_col, cell_code, start_row, start_col, heading, goal_marker
    input  logic [23:0] s_tdata,
    // command
    input  logic [0:0]  s_tuser,
    // stream out
    output logic        m_tvalid,
    input  logic        m_tready,
    // marker_code, marker_row, marker_col, arrive_dir
    output logic [15:0] m_tdata,
    // status
    output logic [2:0]  m_tuser,
    output logic        m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gasp_pkg::*;

    localparam int NCELLS  = MAP_ROWS * MAP_COLS;
    localparam int RW      = $clog2(MAP_ROWS);
    localparam int CLW     = $clog2(MAP_COLS);
    localparam int IDX_W   = $clog2(NCELLS);
    localparam int CNT_W   = $clog2(NCELLS + 1);
    localparam int SCORE_W = $clog2(NCELLS + MAP_ROWS + MAP_COLS + 1);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SCAN  = 4'd1;
    localparam logic [3:0] ST_INIT  = 4'd2;
    localparam logic [3:0] ST_MIN0  = 4'd3;
    localparam logic [3:0] ST_MIN   = 4'd4;
    localparam logic [3:0] ST_PICK  = 4'd5;
    localparam logic [3:0] ST_SHIFT = 4'd6;
    localparam logic [3:0] ST_NBR   = 4'd7;
    localparam logic [3:0] ST_TRACE = 4'd8;
    localparam logic [3:0] ST_EMIT  = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;

    // input fields
    logic [ROW_FW-1:0]         in_cell_row;
    logic [COL_FW-1:0]         in_cell_col;
    logic signed [CODE_FW-1:0] in_cell_code;
    logic [ROW_FW-1:0]         in_start_row;
    logic [COL_FW-1:0]         in_start_col;
    logic [HEAD_FW-1:0]        in_heading;
    logic signed [CODE_FW-1:0] in_goal;
    logic                      in_cmd;

    assign in_cell_row  = s_tdata[2:0];
    assign in_cell_col  = s_tdata[4:3];
    assign in_cell_code = s_tdata[9:5];
    assign in_start_row = s_tdata[12:10];
    assign in_start_col = s_tdata[14:13];
    assign in_heading   = s_tdata[17:15];
    assign in_goal      = s_tdata[22:18];
    assign in_cmd       = s_tuser[0];

    // state
    logic [3:0]                state_reg;
    cfg_t                      cfg_reg;
    logic signed [CODE_FW-1:0] map_reg [NCELLS];
    logic [NCELLS-1:0]         open_reg;
    logic [NCELLS-1:0]         closed_reg;
    logic [RW-1:0]             olr_reg [NCELLS];
    logic [CLW-1:0]            olc_reg [NCELLS];
    logic [CNT_W-1:0]          cost_reg [NCELLS];
    logic [SCORE_W-1:0]        score_reg [NCELLS];
    logic [RW-1:0]             prow_reg [NCELLS];
    logic [CLW-1:0]            pcol_reg [NCELLS];
    logic [DIR_FW-1:0]         dir_reg [NCELLS];
    logic [RW-1:0]             chain_r_reg [NCELLS];
    logic [CLW-1:0]            chain_c_reg [NCELLS];

    logic [ROW_FW-1:0]         in_srow_reg;
    logic [COL_FW-1:0]         in_scol_reg;
    logic [RW-1:0]             st_row_reg;
    logic [CLW-1:0]            st_col_reg;
    logic [RW-1:0]             goal_row_reg;
    logic [CLW-1:0]            goal_col_reg;
    logic signed [CODE_FW-1:0] target_reg;
    logic [2:0]                skip_reg;
    logic                      first_reg;
    logic [IDX_W-1:0]          scan_idx_reg;
    logic [RW-1:0]             scan_row_reg;
    logic [CLW-1:0]            scan_col_reg;
    logic [CNT_W-1:0]          count_reg;
    logic [CNT_W-1:0]          j_reg;
    logic [IDX_W-1:0]          mi_reg;
    logic [SCORE_W-1:0]        best_reg;
    logic [RW-1:0]             cur_row_reg;
    logic [CLW-1:0]            cur_col_reg;
    logic signed [CODE_FW-1:0] ccode_reg;
    logic [CNT_W-1:0]          ccost_reg;
    logic [2:0]                k_reg;
    logic [RW-1:0]             tr_row_reg;
    logic [CLW-1:0]            tr_col_reg;
    logic [CNT_W-1:0]          n_reg;
    logic [CNT_W-1:0]          markers_reg;
    logic [STATUS_FW-1:0]      res_status_reg;

    // result register
    logic                      m_tvalid_reg;
    logic [STATUS_FW-1:0]      out_status_reg;
    logic signed [CODE_FW-1:0] out_code_reg;
    logic [ROW_FW-1:0]         out_row_reg;
    logic [COL_FW-1:0]         out_col_reg;
    logic [DIR_FW-1:0]         out_dir_reg;
    logic                      out_last_reg;

    // derived signals
    logic              slot_free;
    logic              out_load;
    logic              cfg_wr;
    logic              start_ok;
    logic [IDX_W-1:0]  wr_cell;
    logic [IDX_W-1:0]  s_cell;
    logic [IDX_W-1:0]  ol0_cell;
    logic [IDX_W-1:0]  j_idx;
    logic [CNT_W-1:0]  j1;
    logic [IDX_W-1:0]  j_cell;
    logic [RW-1:0]     mi_row;
    logic [CLW-1:0]    mi_col;
    logic [IDX_W-1:0]  mi_cell;
    logic [IDX_W-1:0]  tr_cell;
    logic [CNT_W-1:0]  n_m1;
    logic [RW-1:0]     em_row;
    logic [CLW-1:0]    em_col;
    logic [IDX_W-1:0]  em_cell;
    logic [CNT_W-1:0]  gnew;
    logic [SCORE_W-1:0] nbr_score;
    logic [SCORE_W-1:0] start_score;
    logic [RW-1:0]     nbr_row;
    logic [CLW-1:0]    nbr_col;
    logic [IDX_W-1:0]  nbr_cell;
    nbr_t              nbr_flags;

    function automatic logic [IDX_W-1:0] cell_of(input logic [RW-1:0] r,
                                                 input logic [CLW-1:0] c);
        return IDX_W'(int'(r) * MAP_COLS + int'(c));
    endfunction

    // Manhattan distance to the goal
    function automatic logic [SCORE_W-1:0] heur(input logic [RW-1:0] r,
                                                 input logic [CLW-1:0] c,
                                                 input logic [RW-1:0] gr,
                                                 input logic [CLW-1:0] gc);
        logic [RW-1:0]  dr;
        logic [CLW-1:0] dc;
        dr = (r > gr) ? r - gr : gr - r;
        dc = (c > gc) ? c - gc : gc - c;
        return SCORE_W'(dr) + SCORE_W'(dc);
    endfunction

    assign slot_free = !m_tvalid_reg || m_tready;
    assign out_load  = slot_free && ((state_reg == ST_DONE) ||
                       (state_reg == ST_EMIT && map_reg[em_cell] != CODE_ROAD));
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign start_ok  = (int'(in_srow_reg) < MAP_ROWS) && (int'(in_scol_reg) < MAP_COLS);
    assign wr_cell   = IDX_W'(int'(in_cell_row) * MAP_COLS + int'(in_cell_col));
    assign s_cell    = cell_of(st_row_reg, st_col_reg);
    assign ol0_cell  = cell_of(olr_reg[0], olc_reg[0]);
    assign j_idx     = j_reg[IDX_W-1:0];
    assign j1        = j_reg + CNT_W'(1);
    assign j_cell    = cell_of(olr_reg[j_idx], olc_reg[j_idx]);
    assign mi_row    = olr_reg[mi_reg];
    assign mi_col    = olc_reg[mi_reg];
    assign mi_cell   = cell_of(mi_row, mi_col);
    assign tr_cell   = cell_of(tr_row_reg, tr_col_reg);
    assign n_m1      = n_reg - CNT_W'(1);
    assign em_row    = chain_r_reg[n_m1[IDX_W-1:0]];
    assign em_col    = chain_c_reg[n_m1[IDX_W-1:0]];
    assign em_cell   = cell_of(em_row, em_col);
    assign gnew      = ccost_reg + CNT_W'(1);
    assign nbr_score = SCORE_W'(gnew) + heur(nbr_row, nbr_col, goal_row_reg, goal_col_reg);
    assign start_score = heur(st_row_reg, st_col_reg, goal_row_reg, goal_col_reg);

    // shared neighbour unit
    gasp_nbr #(
        .MAP_ROWS (MAP_ROWS),
        .MAP_COLS (MAP_COLS)
    ) u_nbr (
        .cur_row   (cur_row_reg),
        .cur_col   (cur_col_reg),
        .dir_idx   (k_reg),
        .cur_code  (ccode_reg),
        .nbr_code  (map_reg[nbr_cell]),
        .cfg       (cfg_reg),
        .nbr_row   (nbr_row),
        .nbr_col   (nbr_col),
        .nbr_cell  (nbr_cell),
        .nbr_flags (nbr_flags)
    );

    // sequencer, map and node tables
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cfg_reg.diag_a <= 5'd9;
            cfg_reg.diag_b <= 5'd6;
            cfg_reg.blk_a  <= 5'd7;
            cfg_reg.blk_b  <= 5'd6;
            m_tvalid_reg   <= 1'b0;
            open_reg       <= '0;
            closed_reg     <= '0;
            count_reg      <= '0;
            first_reg      <= 1'b0;
            for (int r = 0; r < MAP_ROWS; r++)
            begin
                for (int c = 0; c < MAP_COLS; c++)
                begin
                    map_reg[r * MAP_COLS + c] <= demo_code(r, c);
                end
            end
        end
        else
        begin
            // take configuration writes
            if (cfg_wr)
            begin
                case (paddr[3:2])
                    REG_DIAG_A: cfg_reg.diag_a <= pwdata[4:0];
                    REG_DIAG_B: cfg_reg.diag_b <= pwdata[4:0];
                    REG_BLK_A:  cfg_reg.blk_a  <= pwdata[4:0];
                    REG_BLK_B:  cfg_reg.blk_b  <= pwdata[4:0];
                    default:    cfg_reg.blk_b  <= cfg_reg.blk_b;
                endcase
            end

            // drop a taken beat unless a new one replaces it
            if (m_tvalid_reg && m_tready && !out_load)
                m_tvalid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        if (in_cmd == CMD_WRITE)
                        begin
                            if (int'(in_cell_row) < MAP_ROWS && int'(in_cell_col) < MAP_COLS)
                                map_reg[wr_cell] <= in_cell_code;
                            res_status_reg <= STS_WRITE_DONE;
                            state_reg      <= ST_DONE;
                        end
                        else
                        begin
                            in_srow_reg  <= in_start_row;
                            in_scol_reg  <= in_start_col;
                            target_reg   <= in_goal;
                            skip_reg     <= (in_heading >= 3'd2) ? in_heading - 3'd2
                                                                 : in_heading;
                            scan_idx_reg <= '0;
                            scan_row_reg <= '0;
                            scan_col_reg <= '0;
                            state_reg    <= ST_SCAN;
                        end
                    end
                end

                // find the goal by row-major scan
                ST_SCAN:
                begin
                    if (map_reg[scan_idx_reg] == target_reg)
                    begin
                        goal_row_reg <= scan_row_reg;
                        goal_col_reg <= scan_col_reg;
                        if (start_ok)
                        begin
                            st_row_reg <= RW'(in_srow_reg);
                            st_col_reg <= CLW'(in_scol_reg);
                            state_reg  <= ST_INIT;
                        end
                        else
                        begin
                            res_status_reg <= STS_UNREACH;
                            state_reg      <= ST_DONE;
                        end
                    end
                    else if (scan_idx_reg == IDX_W'(NCELLS - 1))
                    begin
                        res_status_reg <= STS_NO_GOAL;
                        state_reg      <= ST_DONE;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + IDX_W'(1);
                        if (scan_col_reg == CLW'(MAP_COLS - 1))
                        begin
                            scan_col_reg <= '0;
                            scan_row_reg <= scan_row_reg + RW'(1);
                        end
                        else
                        begin
                            scan_col_reg <= scan_col_reg + CLW'(1);
                        end
                    end
                end

                // seed the open list with the start cell
                ST_INIT:
                begin
                    open_reg           <= {{(NCELLS-1){1'b0}}, 1'b1} << s_cell;
                    closed_reg         <= '0;
                    cost_reg[s_cell]   <= '0;
                    score_reg[s_cell]  <= start_score;
                    prow_reg[s_cell]   <= st_row_reg;
                    pcol_reg[s_cell]   <= st_col_reg;
                    dir_reg[s_cell]    <= '0;
                    olr_reg[0]         <= st_row_reg;
                    olc_reg[0]         <= st_col_reg;
                    count_reg          <= CNT_W'(1);
                    first_reg          <= 1'b1;
                    state_reg          <= ST_MIN0;
                end

                ST_MIN0:
                begin
                    if (count_reg == '0)
                    begin
                        res_status_reg <= STS_UNREACH;
                        state_reg      <= ST_DONE;
                    end
                    else
                    begin
                        mi_reg    <= '0;
                        best_reg  <= score_reg[ol0_cell];
                        j_reg     <= CNT_W'(1);
                        state_reg <= ST_MIN;
                    end
                end

                // search the open list for the lowest score, first wins ties
                ST_MIN:
                begin
                    if (j_reg < count_reg)
                    begin
                        if (score_reg[j_cell] < best_reg)
                        begin
                            best_reg <= score_reg[j_cell];
                            mi_reg   <= j_idx;
                        end
                        j_reg <= j1;
                    end
                    else
                    begin
                        state_reg <= ST_PICK;
                    end
                end

                ST_PICK:
                begin
                    if (mi_row == goal_row_reg && mi_col == goal_col_reg)
                    begin
                        tr_row_reg  <= goal_row_reg;
                        tr_col_reg  <= goal_col_reg;
                        n_reg       <= '0;
                        markers_reg <= '0;
                        state_reg   <= ST_TRACE;
                    end
                    else
                    begin
                        cur_row_reg         <= mi_row;
                        cur_col_reg         <= mi_col;
                        ccode_reg           <= map_reg[mi_cell];
                        ccost_reg           <= cost_reg[mi_cell];
                        open_reg[mi_cell]   <= 1'b0;
                        closed_reg[mi_cell] <= 1'b1;
                        j_reg               <= CNT_W'(mi_reg);
                        state_reg           <= ST_SHIFT;
                    end
                end

                // close the gap left in the open list
                ST_SHIFT:
                begin
                    if (j1 < count_reg)
                    begin
                        olr_reg[j_idx] <= olr_reg[j1[IDX_W-1:0]];
                        olc_reg[j_idx] <= olc_reg[j1[IDX_W-1:0]];
                        j_reg          <= j1;
                    end
                    else
                    begin
                        count_reg <= count_reg - CNT_W'(1);
                        k_reg     <= '0;
                        state_reg <= ST_NBR;
                    end
                end

                // evaluate one neighbour per cycle
                ST_NBR:
                begin
                    if (first_reg && k_reg == skip_reg)
                    begin
                        first_reg <= 1'b0;
                    end
                    else if (nbr_flags.inb && nbr_flags.pass && !closed_reg[nbr_cell])
                    begin
                        if (open_reg[nbr_cell])
                        begin
                            if (gnew < cost_reg[nbr_cell])
                            begin
                                cost_reg[nbr_cell]  <= gnew;
                                score_reg[nbr_cell] <= nbr_score;
                                prow_reg[nbr_cell]  <= cur_row_reg;
                                pcol_reg[nbr_cell]  <= cur_col_reg;
                            end
                        end
                        else if (count_reg < CNT_W'(NCELLS))
                        begin
                            cost_reg[nbr_cell]              <= gnew;
                            score_reg[nbr_cell]             <= nbr_score;
                            prow_reg[nbr_cell]              <= cur_row_reg;
                            pcol_reg[nbr_cell]              <= cur_col_reg;
                            dir_reg[nbr_cell]               <= DIR_FW'(k_reg) + DIR_FW'(1);
                            open_reg[nbr_cell]              <= 1'b1;
                            olr_reg[count_reg[IDX_W-1:0]]   <= nbr_row;
                            olc_reg[count_reg[IDX_W-1:0]]   <= nbr_col;
                            count_reg                       <= count_reg + CNT_W'(1);
                        end
                    end
                    if (k_reg == LAST_DIR)
                    begin
                        first_reg <= 1'b0;
                        state_reg <= ST_MIN0;
                    end
                    else
                    begin
                        k_reg <= k_reg + 3'd1;
                    end
                end

                // walk parents back to the start, count markers
                ST_TRACE:
                begin
                    if (tr_cell != s_cell && n_reg < CNT_W'(NCELLS))
                    begin
                        chain_r_reg[n_reg[IDX_W-1:0]] <= tr_row_reg;
                        chain_c_reg[n_reg[IDX_W-1:0]] <= tr_col_reg;
                        if (map_reg[tr_cell] != CODE_ROAD)
                            markers_reg <= markers_reg + CNT_W'(1);
                        tr_row_reg <= prow_reg[tr_cell];
                        tr_col_reg <= pcol_reg[tr_cell];
                        n_reg      <= n_reg + CNT_W'(1);
                    end
                    else if (markers_reg == '0)
                    begin
                        res_status_reg <= STS_EMPTY;
                        state_reg      <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_EMIT;
                    end
                end

                // emit markers from the start side
                ST_EMIT:
                begin
                    if (slot_free)
                    begin
                        n_reg <= n_m1;
                        if (map_reg[em_cell] != CODE_ROAD)
                        begin
                            m_tvalid_reg   <= 1'b1;
                            out_status_reg <= STS_MARKER;
                            out_code_reg   <= map_reg[em_cell];
                            out_row_reg    <= ROW_FW'(em_row);
                            out_col_reg    <= COL_FW'(em_col);
                            out_dir_reg    <= dir_reg[em_cell];
                            out_last_reg   <= (markers_reg == CNT_W'(1));
                            markers_reg    <= markers_reg - CNT_W'(1);
                            if (markers_reg == CNT_W'(1))
                                state_reg <= ST_IDLE;
                        end
                    end
                end

                // single status beat
                ST_DONE:
                begin
                    if (slot_free)
                    begin
                        m_tvalid_reg   <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_code_reg   <= '0;
                        out_row_reg    <= '0;
                        out_col_reg    <= '0;
                        out_dir_reg    <= '0;
                        out_last_reg   <= 1'b1;
                        state_reg      <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // register read back
    always_comb
    begin
        case (paddr[3:2])
            REG_DIAG_A: prdata = 32'(cfg_reg.diag_a);
            REG_DIAG_B: prdata = 32'(cfg_reg.diag_b);
            REG_BLK_A:  prdata = 32'(cfg_reg.blk_a);
            REG_BLK_B:  prdata = 32'(cfg_reg.blk_b);
            default:    prdata = '0;
        endcase
    end

    assign pready   = 1'b1;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, out_dir_reg, out_col_reg, out_row_reg, out_code_reg};
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule
